FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed: always");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implies");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, expr)
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/wdst_pkg.sv
// constants and types of the wheel drive and speed tracker
`timescale 1ns / 1ps

package wdst_pkg;

	// field and register widths
	localparam int TIME_W    = 48;
	localparam int NUM_W     = 32;
	localparam int SPEED_W   = 24;
	localparam int DUTY_W    = 15;
	localparam int PWR_W     = 16;
	localparam int CNT_W     = 8;
	localparam int DEB_W     = 24;
	localparam int THR_W     = 16;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	// saturation limits
	localparam logic [DUTY_W-1:0]  DUTY_MAX  = 15'd25600;
	localparam logic [SPEED_W-2:0] SPEED_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTDOWN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_LOW   = 3'd4;

	// configuration reset values
	localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 24'd25000;
	localparam logic [CNT_W-1:0] COUNTDOWN_RST = 8'd15;
	localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd1536;
	localparam logic [NUM_W-1:0] NUM_HIGH_RST  = 32'd248933120;
	localparam logic [NUM_W-1:0] NUM_LOW_RST   = 32'd153190400;

	typedef enum logic [1:0] {
		CMD_POWER = 2'd0,
		CMD_EDGE  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_STOPPED   = 3'd0,
		MODE_FWD       = 3'd1,
		MODE_BACK      = 3'd2,
		MODE_STOP_FWD  = 3'd3,
		MODE_STOP_BACK = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		DIR_OFF = 2'd0,
		DIR_FWD = 2'd1,
		DIR_REV = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} ctl_state_t;

endpackage

FILE: hw/rtl/wdst_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wdst_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wdst_pkg::NUM_W-1:0]  dividend,
	input  logic [wdst_pkg::TIME_W-1:0] divisor,
	output logic                       done,
	output logic [wdst_pkg::NUM_W-1:0]  quotient
);
	import wdst_pkg::*;

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] dvs_q;
	logic [NUM_W-1:0]  quo_q;
	logic [TIME_W:0]   trial;
	logic [TIME_W+1:0] diff;
	logic              fits;

	// shift the next dividend bit into the remainder and try the subtract
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign fits  = !diff[TIME_W+1];

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and shared dividend / quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/wheel_drive_and_speed_tracker.sv
// wheel drive and speed tracker: power, sensor edge and tick handling
// steps: power, tick and unused-code beats pass through execute and commit; sensor edges
// take the period, then the check, then for accepted edges the serial divider, then commit
// a new beat is taken only after the last one has been committed; a stalled output holds
// the commit back, and with it the input channel
// reset: motion stopped, speed, duty, counter, edge time and level zero, config at defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wheel_drive_and_speed_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [wdst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wdst_pkg::CFG_W-1:0]      cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      command,
	input  logic signed [wdst_pkg::PWR_W-1:0] power_request,
	input  logic                            sensor_level,
	input  logic [wdst_pkg::TIME_W-1:0]     timestamp,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      drive_direction,
	output logic [wdst_pkg::DUTY_W-1:0]     drive_duty,
	output logic [2:0]                      motion_state,
	output logic signed [wdst_pkg::SPEED_W-1:0] wheel_speed,
	output logic                            speed_published,
	output logic                            edge_accepted
);
	import wdst_pkg::*;

	// configuration registers
	logic [DEB_W-1:0] debounce_q;
	logic [CNT_W-1:0] countdown_q;
	logic [THR_W-1:0] threshold_q;
	logic [NUM_W-1:0] num_high_q;
	logic [NUM_W-1:0] num_low_q;

	// tracker state
	mode_t              mode_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W-1:0]  last_time_q;
	logic               last_level_q;
	logic [SPEED_W-1:0] speed_q;
	logic [DUTY_W-1:0]  duty_q;
	dir_t               dir_q;

	// captured beat
	logic [1:0]        cmd_q;
	logic [PWR_W-1:0]  pwr_q;
	logic              lvl_q;
	logic [TIME_W-1:0] ts_q;
	logic [TIME_W-1:0] period_q;
	logic              edge_ok_q;

	// output register
	logic               out_valid_q;
	dir_t               out_dir_q;
	logic [DUTY_W-1:0]  out_duty_q;
	mode_t              out_mode_q;
	logic [SPEED_W-1:0] out_speed_q;
	logic               out_pub_q;
	logic               out_acc_q;

	// control
	ctl_state_t state_q, state_n;
	logic       in_fire;
	logic       out_free;
	logic       commit;
	logic       edge_ok;
	logic       div_start;
	logic       div_done;
	logic [NUM_W-1:0] quotient;

	// commit datapath
	mode_t              mode_n;
	logic [CNT_W-1:0]   cnt_n;
	logic [SPEED_W-1:0] speed_n;
	logic [DUTY_W-1:0]  duty_n;
	dir_t               dir_n;
	logic               pub_n;
	logic               acc_n;
	logic               pwr_neg;
	logic [PWR_W:0]     pwr_mag;
	logic [PWR_W+5:0]   duty_x25;
	logic [PWR_W+3:0]   duty_raw;
	logic [DUTY_W-1:0]  duty_sat;
	logic [SPEED_W-2:0] q_sat;
	logic [SPEED_W-1:0] speed_mag;
	logic [CNT_W-1:0]   cnt_dec;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			countdown_q <= COUNTDOWN_RST;
			threshold_q <= THRESHOLD_RST;
			num_high_q  <= NUM_HIGH_RST;
			num_low_q   <= NUM_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:  debounce_q  <= cfg_data[DEB_W-1:0];
				REG_COUNTDOWN: countdown_q <= cfg_data[CNT_W-1:0];
				REG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				REG_NUM_HIGH:  num_high_q  <= cfg_data[NUM_W-1:0];
				REG_NUM_LOW:   num_low_q   <= cfg_data[NUM_W-1:0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// debounce and level-change test on the registered period
	assign edge_ok = (period_q > TIME_W'(debounce_q)) && (lvl_q != last_level_q);

	// next state and control strobes
	always_comb begin
		state_n   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_n = ST_EXEC;
			end
			ST_EXEC: begin
				state_n = (cmd_q == CMD_EDGE) ? ST_CHECK : ST_DONE;
			end
			ST_CHECK: begin
				div_start = edge_ok;
				state_n   = edge_ok ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (div_done) state_n = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					commit  = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// beat capture and edge timing
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= command;
			pwr_q <= power_request;
			lvl_q <= sensor_level;
			ts_q  <= timestamp;
		end
		if (state_q == ST_EXEC) period_q <= ts_q - last_time_q;
		if (state_q == ST_CHECK) edge_ok_q <= edge_ok;
	end

	// period division, numerator picked by the new level
	wdst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lvl_q ? num_high_q : num_low_q),
		.divisor  (period_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// duty scaling: |power| * 25 / 4, saturated
	assign pwr_neg  = pwr_q[PWR_W-1];
	assign pwr_mag  = pwr_neg ? ((PWR_W+1)'(1) << PWR_W) - {1'b0, pwr_q} : {1'b0, pwr_q};
	assign duty_x25 = ((PWR_W+6)'(pwr_mag) << 4) + ((PWR_W+6)'(pwr_mag) << 3)
		+ (PWR_W+6)'(pwr_mag);
	assign duty_raw = duty_x25[PWR_W+5:2];
	assign duty_sat = (duty_raw > (PWR_W+4)'(DUTY_MAX)) ? DUTY_MAX : duty_raw[DUTY_W-1:0];

	// speed saturation and magnitude
	assign q_sat     = (|quotient[NUM_W-1:SPEED_W-1]) ? SPEED_MAX : quotient[SPEED_W-2:0];
	assign speed_mag = speed_q[SPEED_W-1] ? (~speed_q + 1'b1) : speed_q;
	assign cnt_dec   = cnt_q - 1'b1;

	// next tracker state for the beat being committed
	always_comb begin
		mode_n  = mode_q;
		cnt_n   = cnt_q;
		speed_n = speed_q;
		duty_n  = duty_q;
		dir_n   = dir_q;
		pub_n   = 1'b0;
		acc_n   = 1'b0;
		case (cmd_q)
			CMD_POWER: begin
				if (pwr_mag == '0) begin
					// zero power: moving wheels start the stop countdown
					if (mode_q == MODE_FWD) begin
						mode_n = MODE_STOP_FWD;
						cnt_n  = countdown_q;
					end else if (mode_q == MODE_BACK) begin
						mode_n = MODE_STOP_BACK;
						cnt_n  = countdown_q;
					end
					dir_n  = DIR_OFF;
					duty_n = '0;
				end else begin
					mode_n = pwr_neg ? MODE_BACK : MODE_FWD;
					cnt_n  = '0;
					dir_n  = pwr_neg ? DIR_REV : DIR_FWD;
					duty_n = duty_sat;
				end
			end
			CMD_EDGE: begin
				acc_n = edge_ok_q;
				if (edge_ok_q) begin
					if (mode_q == MODE_STOPPED) begin
						speed_n = '0;
					end else if (mode_q == MODE_BACK || mode_q == MODE_STOP_BACK) begin
						speed_n = ~{1'b0, q_sat} + 1'b1;
					end else begin
						speed_n = {1'b0, q_sat};
					end
				end
			end
			CMD_TICK: begin
				if (mode_q != MODE_STOPPED) begin
					pub_n = 1'b1;
					if (mode_q == MODE_STOP_FWD || mode_q == MODE_STOP_BACK) begin
						cnt_n = cnt_dec;
						if (cnt_dec == '0) mode_n = MODE_STOPPED;
						if (speed_mag < SPEED_W'(threshold_q)) begin
							speed_n = '0;
							cnt_n   = '0;
							mode_n  = MODE_STOPPED;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// tracker state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_STOPPED;
			cnt_q        <= '0;
			last_time_q  <= '0;
			last_level_q <= 1'b0;
			speed_q      <= '0;
			duty_q       <= '0;
			dir_q        <= DIR_OFF;
		end else begin
			// every edge stores its time and level, accepted or not
			if (state_q == ST_CHECK) begin
				last_time_q  <= ts_q;
				last_level_q <= lvl_q;
			end
			if (commit) begin
				mode_q  <= mode_n;
				cnt_q   <= cnt_n;
				speed_q <= speed_n;
				duty_q  <= duty_n;
				dir_q   <= dir_n;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_dir_q   <= dir_n;
			out_duty_q  <= duty_n;
			out_mode_q  <= mode_n;
			out_speed_q <= speed_n;
			out_pub_q   <= pub_n;
			out_acc_q   <= acc_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_direction = out_dir_q;
	assign drive_duty      = out_duty_q;
	assign motion_state    = out_mode_q;
	assign wheel_speed     = out_speed_q;
	assign speed_published = out_pub_q;
	assign edge_accepted   = out_acc_q;

	// checks
	`ASSERT_ALWAYS(a_drive_off_no_duty, clk, arst_n, (dir_q == DIR_OFF) == (duty_q == '0))
	`ASSERT_IMPLIES(a_div_done_in_div, clk, arst_n, div_done, state_q == ST_DIV)
	`ASSERT_NEXT(a_pass_to_div, clk, arst_n, div_start, state_q == ST_DIV && !div_done)

endmodule
